// ===== rtl/swrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrb_pkg
// Shared types and codes of the retransmission buffer: descriptor layout,
// command and status codes, control group between sequencer and cell row.
// ----------------------------------------------------------------------------
package swrb_pkg;

  localparam int DEFAULT_DEPTH = 16;

  localparam int SEQ_W    = 32;
  localparam int KIND_W   = 2;
  localparam int BYTES_W  = 12;
  localparam int HANDLE_W = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int HELD_W   = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PURGE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [KIND_W-1:0] KIND_LAST = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [KIND_W-1:0]   kind;
    logic [BYTES_W-1:0]  bytes;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctrl_t;

endpackage

// ===== rtl/swrb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrb_in_if / swrb_out_if
// Valid/ready channels for commands and results of the retransmission buffer.
// ----------------------------------------------------------------------------
interface swrb_in_if;
  logic                           valid;
  logic                           ready;
  logic [swrb_pkg::CMD_W-1:0]     command;
  logic [swrb_pkg::SEQ_W-1:0]     seq_key;
  logic [swrb_pkg::KIND_W-1:0]    packet_kind_in;
  logic [swrb_pkg::BYTES_W-1:0]   byte_count_in;
  logic [swrb_pkg::HANDLE_W-1:0]  payload_handle_in;

  modport source (
    output valid, command, seq_key, packet_kind_in, byte_count_in, payload_handle_in,
    input  ready
  );
  modport sink (
    input  valid, command, seq_key, packet_kind_in, byte_count_in, payload_handle_in,
    output ready
  );
endinterface

interface swrb_out_if;
  logic                           valid;
  logic                           ready;
  logic [swrb_pkg::STATUS_W-1:0]  status;
  logic [swrb_pkg::SEQ_W-1:0]     found_seq;
  logic [swrb_pkg::KIND_W-1:0]    found_kind;
  logic [swrb_pkg::BYTES_W-1:0]   found_byte_count;
  logic [swrb_pkg::HANDLE_W-1:0]  found_payload_handle;
  logic                           last_packet_removed;
  logic [swrb_pkg::HELD_W-1:0]    entries_held;

  modport source (
    output valid, status, found_seq, found_kind, found_byte_count, found_payload_handle,
           last_packet_removed, entries_held,
    input  ready
  );
  modport sink (
    input  valid, status, found_seq, found_kind, found_byte_count, found_payload_handle,
           last_packet_removed, entries_held,
    output ready
  );
endinterface

// ===== rtl/swrb_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrb_cell
// One descriptor slot of the row: holds, takes its right neighbor on a
// shift, or takes the broadcast descriptor when addressed.
// ----------------------------------------------------------------------------
module swrb_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  swrb_pkg::chain_ctrl_t ctrl,
  input  logic [IDX_W-1:0]      load_idx,
  input  swrb_pkg::entry_t      load_data,
  input  swrb_pkg::entry_t      right_in,
  output swrb_pkg::entry_t      data
);

  swrb_pkg::entry_t data_r;
  swrb_pkg::entry_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load && (load_idx == IDX_W'(INDEX))) begin
      data_nxt = load_data;
    end else if (ctrl.shift) begin
      data_nxt = right_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== rtl/swrb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrb_ctrl
// Command sequencer: appends on accept without a pass; for the other commands walks the
// row past the head cell, writing kept descriptors back so they land packed.
// ----------------------------------------------------------------------------
module swrb_ctrl #(
  parameter int DEPTH = swrb_pkg::DEFAULT_DEPTH,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  swrb_in_if.sink                in_if,
  swrb_out_if.source             out_if,
  input  swrb_pkg::entry_t       head,
  output swrb_pkg::chain_ctrl_t  ctrl,
  output logic [IDX_W-1:0]       load_idx,
  output swrb_pkg::entry_t       load_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPLY
  } state_t;

  state_t                         state_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [IDX_W-1:0]               step_r;
  logic [CNT_W-1:0]               wr_r;
  logic [swrb_pkg::CMD_W-1:0]     cmd_r;
  logic [swrb_pkg::SEQ_W-1:0]     key_r;
  logic [swrb_pkg::STATUS_W-1:0]  status_r;
  swrb_pkg::entry_t               found_r;
  logic                           hit_r;
  logic                           last_r;

  logic                           out_valid_r;
  logic [swrb_pkg::STATUS_W-1:0]  out_status_r;
  swrb_pkg::entry_t               out_found_r;
  logic                           out_last_r;
  logic [swrb_pkg::HELD_W-1:0]    out_held_r;

  logic             accept;
  logic             live;
  logic             match;
  logic             drop;
  logic             keep;
  logic             hit_nxt;
  logic [CNT_W-1:0] wr_nxt;
  logic [SUM_W-1:0] dest;
  logic             last_step;

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  assign live  = (CNT_W'(step_r) < cnt_r);
  assign match = (head.seq == key_r);
  assign drop  = live && (((cmd_r == swrb_pkg::CMD_REMOVE) && match) ||
                          ((cmd_r == swrb_pkg::CMD_PURGE) && (head.seq < key_r)));
  assign keep  = live && !drop;
  assign wr_nxt  = wr_r + CNT_W'(keep);
  assign hit_nxt = hit_r || ((cmd_r == swrb_pkg::CMD_LOOKUP) && live && match);
  assign last_step = (step_r == IDX_W'(DEPTH - 1));

  // kept descriptor goes where the remaining shifts carry it to slot wr
  assign dest = SUM_W'(wr_r) + SUM_W'(DEPTH - 1) - SUM_W'(step_r);

  always_comb begin
    ctrl.shift = 1'b0;
    ctrl.load  = 1'b0;
    load_idx   = dest[IDX_W-1:0];
    load_data  = head;
    if (state_r == ST_SCAN) begin
      ctrl.shift = 1'b1;
      ctrl.load  = keep;
    end else if (state_r == ST_IDLE) begin
      load_idx         = cnt_r[IDX_W-1:0];
      load_data.seq    = in_if.seq_key;
      load_data.kind   = in_if.packet_kind_in;
      load_data.bytes  = in_if.byte_count_in;
      load_data.handle = in_if.payload_handle_in;
      ctrl.load = accept && (in_if.command == swrb_pkg::CMD_INSERT) &&
                  (cnt_r < CNT_W'(DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a reply in the same cycle refills the output register itself
      if (out_valid_r && out_if.ready && (state_r != ST_REPLY)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r  <= in_if.command;
            key_r  <= in_if.seq_key;
            step_r <= '0;
            wr_r   <= '0;
            hit_r  <= 1'b0;
            last_r <= 1'b0;
            if (in_if.command == swrb_pkg::CMD_INSERT) begin
              if (cnt_r < CNT_W'(DEPTH)) begin
                cnt_r    <= cnt_r + 1'b1;
                status_r <= swrb_pkg::STATUS_OK;
              end else begin
                status_r <= swrb_pkg::STATUS_FULL;
              end
              state_r <= ST_REPLY;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          step_r <= step_r + 1'b1;
          wr_r   <= wr_nxt;
          if (drop && (head.kind == swrb_pkg::KIND_LAST)) begin
            last_r <= 1'b1;
          end
          if (!hit_r && hit_nxt) begin
            found_r <= head;
          end
          hit_r <= hit_nxt;
          if (last_step) begin
            cnt_r   <= wr_nxt;
            state_r <= ST_REPLY;
            priority if (cmd_r == swrb_pkg::CMD_REMOVE) begin
              status_r <= (wr_nxt == cnt_r) ? swrb_pkg::STATUS_NOT_FOUND
                                            : swrb_pkg::STATUS_OK;
            end else if (cmd_r == swrb_pkg::CMD_LOOKUP) begin
              status_r <= hit_nxt ? swrb_pkg::STATUS_OK : swrb_pkg::STATUS_NOT_FOUND;
            end else begin
              status_r <= swrb_pkg::STATUS_OK;
            end
          end
        end
        ST_REPLY: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_found_r  <= hit_r ? found_r : '0;
            out_last_r   <= (cmd_r == swrb_pkg::CMD_PURGE) && last_r;
            out_held_r   <= swrb_pkg::HELD_W'(cnt_r);
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid                = out_valid_r;
  assign out_if.status               = out_status_r;
  assign out_if.found_seq            = out_found_r.seq;
  assign out_if.found_kind           = out_found_r.kind;
  assign out_if.found_byte_count     = out_found_r.bytes;
  assign out_if.found_payload_handle = out_found_r.handle;
  assign out_if.last_packet_removed  = out_last_r;
  assign out_if.entries_held         = out_held_r;

endmodule

// ===== rtl/sliding_window_retransmit_buffer_unit.sv =====
`timescale 1ns / 1ps
// Timing: an insert goes from accept through the reply state to the output
// register; remove, purge and lookup first make one full pass of the
// descriptor row past its head cell. The reply state waits while the output
// is held, and a new command is taken only once the last result is registered.
// Reset: rst_n synchronous, empties the buffer at once; no clearing pass.
// ----------------------------------------------------------------------------
// sliding_window_retransmit_buffer_unit
// Ordered, packed buffer of unacknowledged packet descriptors held in a row
// of shifting cells, with append, remove, purge-below and lookup commands.
// ----------------------------------------------------------------------------
module sliding_window_retransmit_buffer_unit #(
  parameter int WINDOW_DEPTH = swrb_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  swrb_in_if.sink     in_if,
  swrb_out_if.source  out_if
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  swrb_pkg::entry_t      cell_q [WINDOW_DEPTH];
  swrb_pkg::chain_ctrl_t ctrl;
  logic [IDX_W-1:0]      load_idx;
  swrb_pkg::entry_t      load_data;

  swrb_ctrl #(
    .DEPTH (WINDOW_DEPTH),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .head      (cell_q[0]),
    .ctrl      (ctrl),
    .load_idx  (load_idx),
    .load_data (load_data)
  );

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    swrb_pkg::entry_t right;
    if (i == WINDOW_DEPTH - 1) begin : g_tail
      // tail content is never read back during a pass
      assign right = cell_q[i];
    end else begin : g_body
      assign right = cell_q[i+1];
    end

    swrb_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_idx  (load_idx),
      .load_data (load_data),
      .right_in  (right),
      .data      (cell_q[i])
    );
  end

endmodule
